@@ hdl/cvg_pkg.sv @@
// cvg_pkg: shared constants and the arctangent table for the circle vertex generator
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cvg_pkg;

   // field widths
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int COUNT_W  = 7;
   localparam int ARC_W    = 16;
   localparam int PHASE_W  = 16;
   localparam int TRIG_W   = 16;

   // arc units are 1/128 degree
   localparam int FULL_ARC    = 46080;
   localparam int QUARTER_ARC = 11520;
   localparam int RESID_W     = $clog2(QUARTER_ARC);

   // cordic datapath
   localparam int CORDIC_XY_W = 20;
   localparam int CORDIC_Z_W  = 33;
   localparam int ANGLE_FRAC  = 16;
   localparam int ATAN_LEN    = 24;
   localparam int ATAN_IDX_W  = 5;
   localparam int CORDIC_X0   = 19898;
   localparam int TRIG_MAX    = 32767;

   // radius times trig value, Q1.15 rounding
   localparam int FRAC_W     = 15;
   localparam int PROD_W     = 48;
   localparam int ROUND_HALF = 16384;

   // default sizes
   localparam int DEF_MAX_POINTS   = 64;
   localparam int DEF_CORDIC_STEPS = 16;

   // atan(2^-k) in 1/128 degree scaled by 2^16
   function automatic logic signed [CORDIC_Z_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] k);
      logic signed [CORDIC_Z_W-1:0] a;
      case (k)
         5'd0:    a = 33'sd377487360;
         5'd1:    a = 33'sd222843801;
         5'd2:    a = 33'sd117744544;
         5'd3:    a = 33'sd59768969;
         5'd4:    a = 33'sd30000467;
         5'd5:    a = 33'sd15014858;
         5'd6:    a = 33'sd7509261;
         5'd7:    a = 33'sd3754860;
         5'd8:    a = 33'sd1877459;
         5'd9:    a = 33'sd938733;
         5'd10:   a = 33'sd469367;
         5'd11:   a = 33'sd234683;
         5'd12:   a = 33'sd117342;
         5'd13:   a = 33'sd58671;
         5'd14:   a = 33'sd29335;
         5'd15:   a = 33'sd14668;
         5'd16:   a = 33'sd7334;
         5'd17:   a = 33'sd3667;
         5'd18:   a = 33'sd1833;
         5'd19:   a = 33'sd917;
         5'd20:   a = 33'sd458;
         5'd21:   a = 33'sd229;
         5'd22:   a = 33'sd115;
         5'd23:   a = 33'sd57;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cvg_divider.sv @@
// cvg_divider: restoring divider, one quotient bit per cycle
// depends on cvg_pkg (house convention only, no package items needed beyond import)
`timescale 1ns / 1ps
`default_nettype none

module cvg_divider #(
   parameter int DIVIDEND_W = 23,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   import cvg_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});
   end

   // sequencing of the bit steps
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(DIVIDEND_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hdl/cvg_cordic.sv @@
// cvg_cordic: iterative rotation-mode cordic, first quadrant, Q1.15 sine and cosine
// depends on cvg_pkg for widths, start value and the arctangent table
`timescale 1ns / 1ps
`default_nettype none

module cvg_cordic #(
   parameter int STEPS = cvg_pkg::DEF_CORDIC_STEPS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [cvg_pkg::RESID_W-1:0]        angle,
   output logic                                    done,
   output logic signed [cvg_pkg::TRIG_W-1:0]       sin_out,
   output logic signed [cvg_pkg::TRIG_W-1:0]       cos_out
);
   import cvg_pkg::*;

   localparam int STEP_W = $clog2(STEPS);

   logic signed [CORDIC_XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_XY_W-1:0] x_sh, y_sh;
   logic signed [CORDIC_Z_W-1:0]  z_ff, z_in;
   logic signed [CORDIC_Z_W-1:0]  step_angle;
   logic [STEP_W-1:0]             k_ff, k_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;

   // shifted operands and angle for this step
   always_comb begin
      x_sh       = x_ff >>> k_ff;
      y_sh       = y_ff >>> k_ff;
      step_angle = atan_angle(ATAN_IDX_W'(k_ff));
   end

   // micro-rotation and step count
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = CORDIC_XY_W'(CORDIC_X0);
         y_in   = '0;
         z_in   = CORDIC_Z_W'({angle, ANGLE_FRAC'(0)});
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!z_ff[CORDIC_Z_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + step_angle;
         end
         k_in = k_ff + 1'b1;
         if (k_ff == STEP_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
   end

   // rotation registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // clamp to the symmetric Q1.15 range
   always_comb begin
      if (y_ff > CORDIC_XY_W'(TRIG_MAX)) begin
         sin_out = TRIG_W'(TRIG_MAX);
      end else if (y_ff < -CORDIC_XY_W'(TRIG_MAX)) begin
         sin_out = -TRIG_W'(TRIG_MAX);
      end else begin
         sin_out = y_ff[TRIG_W-1:0];
      end
      if (x_ff > CORDIC_XY_W'(TRIG_MAX)) begin
         cos_out = TRIG_W'(TRIG_MAX);
      end else if (x_ff < -CORDIC_XY_W'(TRIG_MAX)) begin
         cos_out = -TRIG_W'(TRIG_MAX);
      end else begin
         cos_out = x_ff[TRIG_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ hdl/cvg_scale.sv @@
// cvg_scale: radius times Q1.15 trig value, rounded, offset by a centre and saturated
// depends on cvg_pkg for widths and rounding constants; the product and the result are registered
`timescale 1ns / 1ps
`default_nettype none

module cvg_scale (
   input  wire logic                                 clock,
   input  wire logic [cvg_pkg::RADIUS_W-1:0]         radius,
   input  wire logic signed [cvg_pkg::TRIG_W-1:0]    trig,
   input  wire logic signed [cvg_pkg::COORD_W-1:0]   center,
   output logic signed [cvg_pkg::COORD_W-1:0]        result
);
   import cvg_pkg::*;

   localparam int RND_W = PROD_W - FRAC_W;
   localparam int SUM_W = RND_W + 1;

   logic signed [COORD_W-1:0] rad_s;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [COORD_W-1:0] cen_ff;
   logic signed [PROD_W-1:0]  biased;
   logic signed [RND_W-1:0]   rounded;
   logic signed [SUM_W-1:0]   sum;
   logic signed [COORD_W-1:0] res_ff, res_in;

   // first stage: the multiply
   always_comb begin
      rad_s   = $signed({1'b0, radius});
      prod_in = PROD_W'(rad_s) * PROD_W'(trig);
   end

   // second stage: round half up, add centre, saturate
   always_comb begin
      biased  = prod_ff + PROD_W'(ROUND_HALF);
      rounded = RND_W'(biased >>> FRAC_W);
      sum     = SUM_W'(rounded) + SUM_W'(cen_ff);
      if ((sum[SUM_W-1:COORD_W-1] == '0) || (sum[SUM_W-1:COORD_W-1] == '1)) begin
         res_in = sum[COORD_W-1:0];
      end else if (sum[SUM_W-1]) begin
         res_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         res_in = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cen_ff  <= center;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

@@ hdl/circle_vertex_generator.sv @@
// circle_vertex_generator: top level, request latch, point sequencer and output register
// depends on cvg_pkg, cvg_divider, cvg_cordic and cvg_scale
`timescale 1ns / 1ps
`default_nettype none

// usage
//   a request transaction (centre, radius, point count, arc) is taken at a rising edge
//   with start high and busy low; busy then stays high until the run is finished
//   the block emits one point per result transaction, each held on the rsp_ ports
//   for exactly one cycle with rsp_strobe high; rsp_last_point marks the final one
//   a point count of zero latches the request and emits nothing, busy stays low
// point processing
//   each point goes through the phase product, a restoring divider (one bit a cycle,
//   MAX width index plus 16 bits), quadrant folding, CORDIC_STEPS cordic iterations
//   and the shared multiply/round/saturate unit used once for x and once for y;
//   the points of a run are made one after another, the next point starts only after
//   the previous one is drained, and busy falls in the cycle of the final strobe
// reset and back pressure
//   synchronous reset returns the sequencer to idle and drops any run in progress
//   the receiver cannot stall: results are not held, so it must take every strobe
module circle_vertex_generator #(
   parameter int MAX_POINTS   = cvg_pkg::DEF_MAX_POINTS,
   parameter int CORDIC_STEPS = cvg_pkg::DEF_CORDIC_STEPS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [cvg_pkg::COORD_W-1:0]  req_center_x,
   input  wire logic signed [cvg_pkg::COORD_W-1:0]  req_center_y,
   input  wire logic signed [cvg_pkg::COORD_W-1:0]  req_center_z,
   input  wire logic [cvg_pkg::RADIUS_W-1:0]        req_radius,
   input  wire logic [cvg_pkg::COUNT_W-1:0]         req_point_count,
   input  wire logic [cvg_pkg::ARC_W-1:0]           req_arc_span,
   output logic                                     rsp_strobe,
   output logic signed [cvg_pkg::COORD_W-1:0]       rsp_vert_x,
   output logic signed [cvg_pkg::COORD_W-1:0]       rsp_vert_y,
   output logic signed [cvg_pkg::COORD_W-1:0]       rsp_vert_z,
   output logic                                     rsp_last_point
);
   import cvg_pkg::*;

   localparam int IDX_W      = $clog2(MAX_POINTS + 1);
   localparam int DIVIDEND_W = IDX_W + ARC_W;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_PROD    = 9'b000000010,
      ST_DIV     = 9'b000000100,
      ST_FOLD    = 9'b000001000,
      ST_ROTATE  = 9'b000010000,
      ST_SCALE_X = 9'b000100000,
      ST_SCALE_Y = 9'b001000000,
      ST_DRAIN_X = 9'b010000000,
      ST_DRAIN_Y = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [RADIUS_W-1:0]       radius_ff;
   logic [ARC_W-1:0]          arc_ff;
   logic [IDX_W-1:0]          total_ff, total_in;
   logic [IDX_W-1:0]          divisor_ff, divisor_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;

   // per point
   logic [PHASE_W-1:0]        phase_ff;
   logic [1:0]                quad_ff, quad_in;
   logic [RESID_W-1:0]        resid;
   logic [PHASE_W-1:0]        wrapped;
   logic signed [TRIG_W-1:0]  sin_ff, cos_ff;
   logic signed [COORD_W-1:0] vx_ff;

   // output register
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                      rsp_last_ff;

   logic                      accept;
   logic [ARC_W-1:0]          arc_clamped;
   logic [COUNT_W-1:0]        count_clamped;
   logic                      last_pt;

   logic                      div_start, div_done;
   logic [DIVIDEND_W-1:0]     dividend, quotient;
   logic                      cor_start, cor_done;
   logic signed [TRIG_W-1:0]  cor_sin, cor_cos;
   logic signed [TRIG_W-1:0]  sc_trig;
   logic signed [COORD_W-1:0] sc_center, sc_result;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // request clamping and phase divisor
   always_comb begin
      arc_clamped   = (req_arc_span > ARC_W'(FULL_ARC)) ? ARC_W'(FULL_ARC) : req_arc_span;
      count_clamped = (req_point_count > COUNT_W'(MAX_POINTS)) ?
                      COUNT_W'(MAX_POINTS) : req_point_count;
      total_in      = IDX_W'(count_clamped);
      if (count_clamped == '0) begin
         divisor_in = '0;
      end else if (arc_clamped == ARC_W'(FULL_ARC)) begin
         divisor_in = total_in;
      end else begin
         divisor_in = total_in - 1'b1;
      end
   end

   assign last_pt = ((IDX_W + 1)'(idx_ff) + 1'b1) == (IDX_W + 1)'(total_ff);

   // quadrant folding of the phase
   always_comb begin
      wrapped = (phase_ff >= PHASE_W'(FULL_ARC)) ? phase_ff - PHASE_W'(FULL_ARC) : phase_ff;
      if (wrapped >= PHASE_W'(3 * QUARTER_ARC)) begin
         quad_in = 2'd3;
         resid   = RESID_W'(wrapped - PHASE_W'(3 * QUARTER_ARC));
      end else if (wrapped >= PHASE_W'(2 * QUARTER_ARC)) begin
         quad_in = 2'd2;
         resid   = RESID_W'(wrapped - PHASE_W'(2 * QUARTER_ARC));
      end else if (wrapped >= PHASE_W'(QUARTER_ARC)) begin
         quad_in = 2'd1;
         resid   = RESID_W'(wrapped - PHASE_W'(QUARTER_ARC));
      end else begin
         quad_in = 2'd0;
         resid   = RESID_W'(wrapped);
      end
   end

   // point sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (count_clamped != '0)) begin
               state_in = ST_PROD;
               idx_in   = '0;
            end
         end
         ST_PROD:    state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD:    state_in = ST_ROTATE;
         ST_ROTATE: begin
            if (cor_done) begin
               state_in = ST_SCALE_X;
            end
         end
         ST_SCALE_X: state_in = ST_SCALE_Y;
         ST_SCALE_Y: state_in = ST_DRAIN_X;
         ST_DRAIN_X: state_in = ST_DRAIN_Y;
         ST_DRAIN_Y: begin
            idx_in   = idx_ff + 1'b1;
            state_in = last_pt ? ST_IDLE : ST_PROD;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         total_ff     <= '0;
         divisor_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= (state_ff == ST_DRAIN_Y);
         if (accept) begin
            total_ff   <= total_in;
            divisor_ff <= divisor_in;
         end
      end
   end

   // request and point data registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff     <= req_center_x;
         cy_ff     <= req_center_y;
         cz_ff     <= req_center_z;
         radius_ff <= req_radius;
         arc_ff    <= arc_clamped;
      end
      if ((state_ff == ST_DIV) && div_done) begin
         phase_ff <= (divisor_ff == '0) ? '0 : quotient[PHASE_W-1:0];
      end
      if (state_ff == ST_FOLD) begin
         quad_ff <= quad_in;
      end
      if ((state_ff == ST_ROTATE) && cor_done) begin
         case (quad_ff)
            2'd0: begin
               sin_ff <= cor_sin;
               cos_ff <= cor_cos;
            end
            2'd1: begin
               sin_ff <= cor_cos;
               cos_ff <= -cor_sin;
            end
            2'd2: begin
               sin_ff <= -cor_sin;
               cos_ff <= -cor_cos;
            end
            default: begin
               sin_ff <= -cor_cos;
               cos_ff <= cor_sin;
            end
         endcase
      end
      if (state_ff == ST_DRAIN_X) begin
         vx_ff <= sc_result;
      end
      if (state_ff == ST_DRAIN_Y) begin
         rsp_x_ff    <= vx_ff;
         rsp_y_ff    <= sc_result;
         rsp_z_ff    <= cz_ff;
         rsp_last_ff <= last_pt;
      end
   end

   // phase = index * arc / divisor
   assign div_start = (state_ff == ST_PROD);
   assign dividend  = DIVIDEND_W'(idx_ff) * DIVIDEND_W'(arc_ff);

   cvg_divider #(
      .DIVIDEND_W (DIVIDEND_W),
      .DIVISOR_W  (IDX_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // sine and cosine of the folded phase
   assign cor_start = (state_ff == ST_FOLD);

   cvg_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (resid),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   // shared scale unit: x issued in one cycle, y in the next
   always_comb begin
      if (state_ff == ST_SCALE_X) begin
         sc_trig   = sin_ff;
         sc_center = cx_ff;
      end else begin
         sc_trig   = cos_ff;
         sc_center = cy_ff;
      end
   end

   cvg_scale u_scale (
      .clock  (clock),
      .radius (radius_ff),
      .trig   (sc_trig),
      .center (sc_center),
      .result (sc_result)
   );

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_vert_x     = rsp_x_ff;
   assign rsp_vert_y     = rsp_y_ff;
   assign rsp_vert_z     = rsp_z_ff;
   assign rsp_last_point = rsp_valid_ff && rsp_last_ff;

   // a result transaction only follows the final step of a point
   a_strobe_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DRAIN_Y))
      else $error("result strobe without a finished point");

   // a request with points makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && (count_clamped != '0)) |=> busy)
      else $error("accepted request did not start a run");

   // the point index stays inside the run
   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      (busy && (state_ff != ST_IDLE)) |-> (idx_ff < total_ff))
      else $error("point index beyond point count");

   // the divider only reports done during the divide step
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for circle_vertex_generator, directed then random requests
// depends on cvg_pkg (widths, arc constants) and the circle_vertex_generator rtl
`timescale 1ns / 1ps

module tb;

   import cvg_pkg::*;

   localparam int POINT_LIMIT  = DEF_MAX_POINTS;
   localparam int CORDIC_ITERS = DEF_CORDIC_STEPS;
   localparam int RANDOM_REQS  = 102;
   localparam int DRAIN_CYCLES = 200;
   localparam int CALM_FIRST   = 50;
   localparam int CALM_LAST    = 80;

   localparam logic [ARC_W-1:0] FULL_SPAN = ARC_W'(FULL_ARC);

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [RADIUS_W-1:0]       radius;
      logic [COUNT_W-1:0]        count;
      logic [ARC_W-1:0]          arc;
   } circle_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } vertex_type;

   typedef struct packed {
      logic signed [31:0] sn;
      logic signed [31:0] cs;
   } trig_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic signed [COORD_W-1:0] req_center_z = '0;
   logic [RADIUS_W-1:0]       req_radius = '0;
   logic [COUNT_W-1:0]        req_point_count = '0;
   logic [ARC_W-1:0]          req_arc_span = '0;
   logic                      rsp_strobe;
   logic signed [COORD_W-1:0] rsp_vert_x;
   logic signed [COORD_W-1:0] rsp_vert_y;
   logic signed [COORD_W-1:0] rsp_vert_z;
   logic                      rsp_last_point;

   circle_req_type pending_requests[$];
   vertex_type     expected_points[$];

   int accepted_count = 0;
   int empty_requests = 0;
   int points_checked = 0;
   int error_count    = 0;

   // atan(2^-k) in 1/128 degree scaled by 2^16
   longint arctan_units [0:23] = '{
      377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
      7509261, 3754860, 1877459, 938733, 469367, 234683,
      117342, 58671, 29335, 14668, 7334, 3667,
      1833, 917, 458, 229, 115, 57
   };

   circle_vertex_generator #(
      .MAX_POINTS   (POINT_LIMIT),
      .CORDIC_STEPS (CORDIC_ITERS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_center_z    (req_center_z),
      .req_radius      (req_radius),
      .req_point_count (req_point_count),
      .req_arc_span    (req_arc_span),
      .rsp_strobe      (rsp_strobe),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_last_point  (rsp_last_point)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_trig(input longint v);
      if (v > TRIG_MAX) return TRIG_MAX;
      if (v < -TRIG_MAX) return -TRIG_MAX;
      return v;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // first-quadrant cordic, then folded by quadrant
   function automatic trig_pair_type quadrant_sincos(input int phase);
      longint x, y, z, nx, s0, c0;
      int quad, resid;
      trig_pair_type tp;
      if (phase >= FULL_ARC) phase = phase - FULL_ARC;
      quad  = phase / QUARTER_ARC;
      resid = phase % QUARTER_ARC;
      x = CORDIC_X0;
      y = 0;
      z = longint'(resid) * 65536;
      for (int k = 0; k < CORDIC_ITERS && k < 24; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            y  = y + (x >>> k);
            z  = z - arctan_units[k];
         end else begin
            nx = x + (y >>> k);
            y  = y - (x >>> k);
            z  = z + arctan_units[k];
         end
         x = nx;
      end
      s0 = clamp_trig(y);
      c0 = clamp_trig(x);
      case (quad)
         0: begin
            tp.sn = 32'(s0);  tp.cs = 32'(c0);
         end
         1: begin
            tp.sn = 32'(c0);  tp.cs = 32'(-s0);
         end
         2: begin
            tp.sn = 32'(-s0); tp.cs = 32'(-c0);
         end
         default: begin
            tp.sn = 32'(-c0); tp.cs = 32'(s0);
         end
      endcase
      return tp;
   endfunction

   // radius times Q1.15 trig, rounded half up
   function automatic longint scale_by_trig(input logic [RADIUS_W-1:0] r, input longint t);
      longint rl;
      rl = r;
      return (rl * t + ROUND_HALF) >>> FRAC_W;
   endfunction

   // expected points of one accepted request transaction
   function automatic void predict_arc_points(input circle_req_type rq);
      int arc, count, divisor, phase;
      longint cx, cy, cz;
      trig_pair_type tp;
      vertex_type v;
      cx = longint'($signed(rq.cx));
      cy = longint'($signed(rq.cy));
      cz = longint'($signed(rq.cz));
      arc   = (rq.arc > FULL_ARC) ? FULL_ARC : int'(rq.arc);
      count = (rq.count > POINT_LIMIT) ? POINT_LIMIT : int'(rq.count);
      if (count == 0)
         divisor = 0;
      else if (arc == FULL_ARC)
         divisor = count;
      else
         divisor = count - 1;
      if (count == 0) empty_requests++;
      for (int i = 0; i < count; i++) begin
         phase = (divisor != 0) ? (i * arc) / divisor : 0;
         tp = quadrant_sincos(phase);
         v.x = clip32(cx + scale_by_trig(rq.radius, longint'(tp.sn)));
         v.y = clip32(cy + scale_by_trig(rq.radius, longint'(tp.cs)));
         v.z = clip32(cz);
         v.last = (i + 1 == count);
         expected_points = {expected_points, v};
      end
   endfunction

   task automatic add_request(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [RADIUS_W-1:0] r,
                              input logic [COUNT_W-1:0] n, input logic [ARC_W-1:0] a);
      circle_req_type rq;
      rq.cx = cx;
      rq.cy = cy;
      rq.cz = cz;
      rq.radius = r;
      rq.count = n;
      rq.arc = a;
      pending_requests = {pending_requests, rq};
   endtask

   // mostly small counts and modest coordinates, with full-range outliers
   task automatic add_random_request();
      logic [31:0] cx, cy, cz;
      logic [RADIUS_W-1:0] r;
      logic [COUNT_W-1:0] n;
      logic [ARC_W-1:0] a;
      int sel;
      cx = $urandom;
      cy = $urandom;
      cz = $urandom;
      if ($urandom_range(99) < 70) begin
         cx = {{10{cx[21]}}, cx[21:0]};
         cy = {{10{cy[21]}}, cy[21:0]};
      end
      r = RADIUS_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 5)
         r = '0;
      else if (sel < 65)
         r = r & 31'h00FF_FFFF;
      sel = $urandom_range(99);
      if (sel < 4)
         n = '0;
      else if (sel < 10)
         n = COUNT_W'($urandom_range(127, 65));
      else if (sel < 18)
         n = COUNT_W'($urandom_range(64, 9));
      else
         n = COUNT_W'($urandom_range(8, 1));
      sel = $urandom_range(99);
      if (sel < 25)
         a = FULL_SPAN;
      else if (sel < 35)
         a = ARC_W'($urandom_range(65535, 0));
      else
         a = ARC_W'($urandom_range(FULL_ARC - 1, 0));
      add_request(cx, cy, cz, r, n, a);
   endtask

   // driver: holds start with the oldest pending request until it is taken
   always @(posedge clock) begin : drive
      logic holding;
      logic idle_now;
      holding  = start && busy;
      idle_now = (accepted_count >= CALM_FIRST && accepted_count < CALM_LAST) ? 1'b0 :
                 ($urandom_range(99) < 13);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_arc_points(pending_requests.pop_front());
            accepted_count++;
         end
         if (!holding) begin
            if (pending_requests.size() > 0 && !idle_now) begin
               req_center_x    <= pending_requests[0].cx;
               req_center_y    <= pending_requests[0].cy;
               req_center_z    <= pending_requests[0].cz;
               req_radius      <= pending_requests[0].radius;
               req_point_count <= pending_requests[0].count;
               req_arc_span    <= pending_requests[0].arc;
               start           <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each strobed point against the oldest expected point
   always @(posedge clock) begin : watch
      vertex_type e;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("tb: unexpected point x=%h y=%h z=%h last=%b",
                        rsp_vert_x, rsp_vert_y, rsp_vert_z, rsp_last_point);
         end else begin
            e = expected_points.pop_front();
            points_checked++;
            if (rsp_vert_x !== e.x || rsp_vert_y !== e.y || rsp_vert_z !== e.z ||
                rsp_last_point !== e.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("tb: point %0d exp %h %h %h %b, got %h %h %h %b",
                           points_checked, e.x, e.y, e.z, e.last,
                           rsp_vert_x, rsp_vert_y, rsp_vert_z, rsp_last_point);
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      // single point at the centre, radius zero
      add_request(32'h0, 32'h0, 32'h0, 31'h0, 7'd1, 16'd0);
      // single point on a full circle
      add_request(32'h0001_0000, 32'hFFFF_0000, 32'h7, 31'h0001_0000, 7'd1, FULL_SPAN);
      // quadrant boundaries
      add_request(32'h0, 32'h0, 32'h0, 31'h000A_0000, 7'd4, FULL_SPAN);
      add_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 31'h0004_8000, 7'd5, 16'd23040);
      // zero count, then another zero count back to back, then a point
      add_request(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 31'h0123_4567, 7'd0, 16'd100);
      add_request(32'hFFFF_FFFF, 32'h0, 32'h0, 31'h7FFF_FFFF, 7'd0, 16'hFFFF);
      add_request(32'h0, 32'h0, 32'h0, 31'h0002_0000, 7'd1, 16'd11520);
      // largest count, largest radius
      add_request(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 7'd64, FULL_SPAN);
      // counts above the limit
      add_request(32'h0010_0000, 32'h0, 32'h0, 31'h0003_0000, 7'd65, 16'd11520);
      add_request(32'h0, 32'h0, 32'hFFFF_FFFF, 31'h0000_8000, 7'd127, 16'd46081);
      // arc beyond a full circle
      add_request(32'h0, 32'h0, 32'h0, 31'h0005_0000, 7'd3, 16'hFFFF);
      add_request(32'h0, 32'h0, 32'h0, 31'h0005_0000, 7'd1, 16'hFFFF);
      // arc just short of a full circle
      add_request(32'h0, 32'h0, 32'h0, 31'h0005_0000, 7'd2, FULL_SPAN - 1'b1);
      // saturation high and low
      add_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd8, FULL_SPAN);
      add_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 7'd8, FULL_SPAN);
      // smallest nonzero arc
      add_request(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 7'd7, 16'd1);
      // alternating bit patterns
      add_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 7'd6, 16'hAAAA);
      add_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 7'd42, 16'h5555);
      for (int i = 0; i < RANDOM_REQS; i++)
         add_random_request();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || start)
         @(posedge clock);
      while (expected_points.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      error_count = error_count + expected_points.size();
      $display("tb: %0d requests taken (%0d with no points), %0d points checked",
               accepted_count, empty_requests, points_checked);
      $display("tb: %0d failures", error_count);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #30_000_000;
      $display("tb: timed out");
      $display("tb: done, errors");
      $finish;
   end

endmodule
